@@ hw/rtl/bola_pkg.sv @@
// Shared constants, types and sequencer states of the box overlap label assigner.
`timescale 1ns / 1ps
`default_nettype none
package bola_pkg;

  localparam int DEF_MAX_DETECTIONS = 32;
  localparam int DEF_MAX_SEGMENTS   = 32;
  localparam int DEF_COORD_BITS     = 12;

  localparam int THR_W       = 16;
  localparam int ID_W        = 11;
  localparam int SEG_INDEX_W = 5;

  localparam logic [THR_W-1:0]       THR_RESET = 16'd32768;
  localparam logic signed [ID_W-1:0] ID_NONE   = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG_RD,
    ST_SEG_AREA,
    ST_SEG_LIM,
    ST_DET_RD,
    ST_DET_OVL,
    ST_DET_INTER,
    ST_DET_AREA,
    ST_DET_UPD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                   valid;
    logic [SEG_INDEX_W-1:0] idx;
    logic signed [ID_W-1:0] id;
    logic                   last;
  } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/bola_box_mem.sv @@
// Box store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bola_box_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 59,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/bola_mul.sv @@
// Shared multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module bola_mul #(
  parameter int A_W = 16,
  parameter int B_W = 24
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [A_W-1:0]     op_a,
  input  wire logic [B_W-1:0]     op_b,
  output logic      [A_W+B_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bola_seq.sv @@
// Matching sequencer: walks segments and detections around one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module bola_seq #(
  parameter int MAX_DETECTIONS = bola_pkg::DEF_MAX_DETECTIONS,
  parameter int MAX_SEGMENTS   = bola_pkg::DEF_MAX_SEGMENTS,
  parameter int COORD_BITS     = bola_pkg::DEF_COORD_BITS,
  localparam int DA_W    = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1,
  localparam int SA_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
  localparam int DC_W    = $clog2(MAX_DETECTIONS + 1),
  localparam int SC_W    = $clog2(MAX_SEGMENTS + 1),
  localparam int ENTRY_W = 4 * COORD_BITS + bola_pkg::ID_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [DC_W-1:0]               det_cnt,
  input  wire logic [SC_W-1:0]               seg_cnt,
  input  wire logic [bola_pkg::THR_W-1:0]    thr,
  output logic      [DA_W-1:0]               det_addr,
  output logic      [SA_W-1:0]               seg_addr,
  input  wire logic [ENTRY_W-1:0]            det_q,
  input  wire logic [ENTRY_W-1:0]            seg_q,
  output logic                               busy,
  output bola_pkg::res_t                     res,
  input  wire logic                          res_take
);

  localparam int CB   = COORD_BITS;
  localparam int ID_W = bola_pkg::ID_W;
  localparam int MA   = (CB > bola_pkg::THR_W) ? CB : bola_pkg::THR_W;
  localparam int MB   = 2 * CB;
  localparam int PW   = MA + MB;

  bola_pkg::state_t state_r, state_nxt;
  logic [SA_W-1:0] k_r, k_nxt;
  logic [DA_W-1:0] i_r, i_nxt;
  logic [CB-1:0]   ox_r, ox_nxt, oy_r, oy_nxt;
  logic [PW-1:0]   lim_r, lim_nxt;
  logic            pass_r, pass_nxt;
  logic            found_r, found_nxt;
  logic [MB-1:0]   best_area_r, best_area_nxt;
  logic signed [ID_W-1:0] best_id_r, best_id_nxt;
  logic signed [ID_W-1:0] res_id_r, res_id_nxt;

  logic          mul_en;
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [PW-1:0] mul_r;

  // Entry fields
  logic [CB-1:0] s_x, s_y, s_w, s_h, d_x, d_y, d_w, d_h;
  logic signed [ID_W-1:0] s_id, d_id;

  assign s_x  = seg_q[CB-1:0];
  assign s_y  = seg_q[2*CB-1:CB];
  assign s_w  = seg_q[3*CB-1:2*CB];
  assign s_h  = seg_q[4*CB-1:3*CB];
  assign s_id = seg_q[4*CB+ID_W-1:4*CB];
  assign d_x  = det_q[CB-1:0];
  assign d_y  = det_q[2*CB-1:CB];
  assign d_w  = det_q[3*CB-1:2*CB];
  assign d_h  = det_q[4*CB-1:3*CB];
  assign d_id = det_q[4*CB+ID_W-1:4*CB];

  // 1-D overlaps; right and bottom edges carry one extra bit
  logic [CB:0] sx_end, dx_end, sy_end, dy_end, x_hi, y_hi, x_lo, y_lo, x_ov, y_ov;

  always_comb begin
    sx_end = {1'b0, s_x} + {1'b0, s_w};
    dx_end = {1'b0, d_x} + {1'b0, d_w};
    sy_end = {1'b0, s_y} + {1'b0, s_h};
    dy_end = {1'b0, d_y} + {1'b0, d_h};
    x_lo   = (s_x > d_x) ? {1'b0, s_x} : {1'b0, d_x};
    y_lo   = (s_y > d_y) ? {1'b0, s_y} : {1'b0, d_y};
    x_hi   = (sx_end < dx_end) ? sx_end : dx_end;
    y_hi   = (sy_end < dy_end) ? sy_end : dy_end;
    x_ov   = (x_hi > x_lo) ? x_hi - x_lo : '0;
    y_ov   = (y_hi > y_lo) ? y_hi - y_lo : '0;
  end

  logic [PW-1:0] inter_sh;
  logic          seg_last, det_last, upd;
  logic [SA_W+bola_pkg::SEG_INDEX_W-1:0] k_ext;

  assign inter_sh = PW'({mul_r[MB-1:0], {bola_pkg::THR_W{1'b0}}});
  assign seg_last = (SC_W'(k_r) + 1'b1) == seg_cnt;
  assign det_last = (DC_W'(i_r) + 1'b1) == det_cnt;
  assign upd      = pass_r && (!found_r || (mul_r[MB-1:0] < best_area_r));
  assign k_ext    = {{bola_pkg::SEG_INDEX_W{1'b0}}, k_r};

  bola_mul #(.A_W(MA), .B_W(MB)) u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bola_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    i_r         <= i_nxt;
    ox_r        <= ox_nxt;
    oy_r        <= oy_nxt;
    lim_r       <= lim_nxt;
    pass_r      <= pass_nxt;
    found_r     <= found_nxt;
    best_area_r <= best_area_nxt;
    best_id_r   <= best_id_nxt;
    res_id_r    <= res_id_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    lim_nxt       = lim_r;
    pass_nxt      = pass_r;
    found_nxt     = found_r;
    best_area_nxt = best_area_r;
    best_id_nxt   = best_id_r;
    res_id_nxt    = res_id_r;
    mul_en        = 1'b0;
    mul_a         = MA'(s_w);
    mul_b         = MB'(s_h);

    unique case (state_r)
      bola_pkg::ST_IDLE: begin
        if (start) begin
          k_nxt     = '0;
          state_nxt = bola_pkg::ST_SEG_RD;
        end
      end
      bola_pkg::ST_SEG_RD: begin
        state_nxt = bola_pkg::ST_SEG_AREA;
      end
      bola_pkg::ST_SEG_AREA: begin
        mul_en = 1'b1;
        if (s_id != bola_pkg::ID_NONE) begin
          res_id_nxt = s_id;
          state_nxt  = bola_pkg::ST_EMIT;
        end else begin
          state_nxt = bola_pkg::ST_SEG_LIM;
        end
      end
      bola_pkg::ST_SEG_LIM: begin
        mul_a = MA'(thr);
        mul_b = mul_r[MB-1:0];
        if (mul_r == '0 || det_cnt == '0) begin
          res_id_nxt = bola_pkg::ID_NONE;
          state_nxt  = bola_pkg::ST_EMIT;
        end else begin
          mul_en      = 1'b1;
          i_nxt       = '0;
          found_nxt   = 1'b0;
          best_id_nxt = bola_pkg::ID_NONE;
          state_nxt   = bola_pkg::ST_DET_RD;
        end
      end
      bola_pkg::ST_DET_RD: begin
        if (i_r == '0) begin
          lim_nxt = mul_r;
        end
        state_nxt = bola_pkg::ST_DET_OVL;
      end
      bola_pkg::ST_DET_OVL: begin
        ox_nxt = x_ov[CB-1:0];
        oy_nxt = y_ov[CB-1:0];
        if (d_id == bola_pkg::ID_NONE) begin
          pass_nxt  = 1'b0;
          state_nxt = bola_pkg::ST_DET_UPD;
        end else begin
          state_nxt = bola_pkg::ST_DET_INTER;
        end
      end
      bola_pkg::ST_DET_INTER: begin
        mul_en    = 1'b1;
        mul_a     = MA'(ox_r);
        mul_b     = MB'(oy_r);
        state_nxt = bola_pkg::ST_DET_AREA;
      end
      bola_pkg::ST_DET_AREA: begin
        mul_en    = 1'b1;
        mul_a     = MA'(d_w);
        mul_b     = MB'(d_h);
        pass_nxt  = inter_sh > lim_r;
        state_nxt = bola_pkg::ST_DET_UPD;
      end
      bola_pkg::ST_DET_UPD: begin
        if (upd) begin
          found_nxt     = 1'b1;
          best_area_nxt = mul_r[MB-1:0];
          best_id_nxt   = d_id;
        end
        if (det_last) begin
          res_id_nxt = upd ? d_id : best_id_r;
          state_nxt  = bola_pkg::ST_EMIT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = bola_pkg::ST_DET_RD;
        end
      end
      bola_pkg::ST_EMIT: begin
        if (res_take) begin
          if (seg_last) begin
            state_nxt = bola_pkg::ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = bola_pkg::ST_SEG_RD;
          end
        end
      end
      default: begin
        state_nxt = bola_pkg::ST_IDLE;
      end
    endcase
  end

  assign det_addr  = i_r;
  assign seg_addr  = k_r;
  assign busy      = state_r != bola_pkg::ST_IDLE;
  assign res.valid = state_r == bola_pkg::ST_EMIT;
  assign res.idx   = k_ext[bola_pkg::SEG_INDEX_W-1:0];
  assign res.id    = res_id_r;
  assign res.last  = seg_last;

endmodule
`default_nettype wire

@@ hw/rtl/box_overlap_label_assign_top.sv @@
// Top level of the box overlap label assigner: loading, counts, threshold and result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  in_     | input     | in_valid / in_stall | req_type, box_x/y/w/h, box_id, last_item
//  out_    | output    | out_valid/out_stall | seg_index, assigned_id, last_result
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_data: overlap threshold (unsigned Q0.16)
//
// Loading takes one word a cycle while idle; the word flagged last_item starts matching
// if segments are stored; the input stalls until the last result is in the output register.
// Per segment box: read, own area, threshold product; per stored detection: read, overlap,
// intersection, area, update (one without a class id skips intersection and area); hand-over
// waits on output stall; a segment with own id, zero area or no detections skips the walk.
// Synchronous active-low reset clears counts, sequencer, output valid; threshold to half.
`timescale 1ns / 1ps
`default_nettype none
module box_overlap_label_assign_top #(
  parameter int MAX_DETECTIONS = bola_pkg::DEF_MAX_DETECTIONS,
  parameter int MAX_SEGMENTS   = bola_pkg::DEF_MAX_SEGMENTS,
  parameter int COORD_BITS     = bola_pkg::DEF_COORD_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // loading words
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_req_type,
  input  wire logic [COORD_BITS-1:0]                 in_box_x,
  input  wire logic [COORD_BITS-1:0]                 in_box_y,
  input  wire logic [COORD_BITS-1:0]                 in_box_w,
  input  wire logic [COORD_BITS-1:0]                 in_box_h,
  input  wire logic signed [bola_pkg::ID_W-1:0]      in_box_id,
  input  wire logic                                  in_last_item,
  // result words
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [bola_pkg::SEG_INDEX_W-1:0]           out_seg_index,
  output logic signed [bola_pkg::ID_W-1:0]           out_assigned_id,
  output logic                                       out_last_result,
  // threshold register
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [bola_pkg::THR_W-1:0]            cfg_data
);

  localparam int DA_W    = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int SA_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int DC_W    = $clog2(MAX_DETECTIONS + 1);
  localparam int SC_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int ENTRY_W = 4 * COORD_BITS + bola_pkg::ID_W;

  logic [bola_pkg::THR_W-1:0] thr_r, thr_nxt;
  logic [DC_W-1:0] det_cnt_r, det_cnt_nxt;
  logic [SC_W-1:0] seg_cnt_r, seg_cnt_nxt, seg_cnt_after;

  logic                out_valid_r, out_valid_nxt;
  logic [bola_pkg::SEG_INDEX_W-1:0] out_idx_r;
  logic signed [bola_pkg::ID_W-1:0] out_id_r;
  logic                out_last_r;

  logic               accept, det_we, seg_we, start, busy, res_take;
  logic [ENTRY_W-1:0] entry, det_q, seg_q;
  logic [DA_W-1:0]    det_addr;
  logic [SA_W-1:0]    seg_addr;
  bola_pkg::res_t     res;

  // Threshold register: always writable, only changed while idle by contract
  assign cfg_ready = 1'b1;
  assign thr_nxt   = cfg_valid ? cfg_data : thr_r;

  // Accept a word only while the sequencer is idle
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign entry    = {in_box_id, in_box_h, in_box_w, in_box_y, in_box_x};

  // Drop words that arrive at a full store; the last flag still starts matching
  assign det_we = accept && !in_req_type && (det_cnt_r != DC_W'(MAX_DETECTIONS));
  assign seg_we = accept && in_req_type && (seg_cnt_r != SC_W'(MAX_SEGMENTS));
  assign seg_cnt_after = seg_cnt_r + SC_W'(seg_we);
  assign start = accept && in_last_item && (seg_cnt_after != '0);

  // Counts return to zero at frame end: on the last result handed over, or at
  // once when a frame closes with no segment box
  always_comb begin
    det_cnt_nxt = det_cnt_r + DC_W'(det_we);
    seg_cnt_nxt = seg_cnt_after;
    if ((accept && in_last_item && seg_cnt_after == '0) || (res_take && res.last)) begin
      det_cnt_nxt = '0;
      seg_cnt_nxt = '0;
    end
  end

  // Result register parts the sequencer from the output stall
  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= bola_pkg::THR_RESET;
      det_cnt_r   <= '0;
      seg_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      thr_r       <= thr_nxt;
      det_cnt_r   <= det_cnt_nxt;
      seg_cnt_r   <= seg_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the result register: load on hand-over, hold otherwise
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_idx_r  <= res.idx;
      out_id_r   <= res.id;
      out_last_r <= res.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seg_index   = out_idx_r;
  assign out_assigned_id = out_id_r;
  assign out_last_result = out_last_r;

  bola_box_mem #(.DEPTH(MAX_DETECTIONS), .WIDTH(ENTRY_W)) u_det_mem (
    .clk       (clk),
    .wr_en     (det_we),
    .wr_addr   (det_cnt_r[DA_W-1:0]),
    .wr_data   (entry),
    .rd_addr   (det_addr),
    .rd_data_r (det_q)
  );

  bola_box_mem #(.DEPTH(MAX_SEGMENTS), .WIDTH(ENTRY_W)) u_seg_mem (
    .clk       (clk),
    .wr_en     (seg_we),
    .wr_addr   (seg_cnt_r[SA_W-1:0]),
    .wr_data   (entry),
    .rd_addr   (seg_addr),
    .rd_data_r (seg_q)
  );

  bola_seq #(
    .MAX_DETECTIONS (MAX_DETECTIONS),
    .MAX_SEGMENTS   (MAX_SEGMENTS),
    .COORD_BITS     (COORD_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .det_cnt  (det_cnt_r),
    .seg_cnt  (seg_cnt_r),
    .thr      (thr_r),
    .det_addr (det_addr),
    .seg_addr (seg_addr),
    .det_q    (det_q),
    .seg_q    (seg_q),
    .busy     (busy),
    .res      (res),
    .res_take (res_take)
  );

`ifndef SYNTHESIS
  // A pending match result means the loading side is held off
  a_res_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> in_stall)
    else $error("result pending while input open");

  // Handing over the final result closes the frame
  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_take && res.last |=> (det_cnt_r == '0) && (seg_cnt_r == '0) && !in_stall)
    else $error("frame not closed after final result");

  // Counts never pass their store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (det_cnt_r <= DC_W'(MAX_DETECTIONS)) && (seg_cnt_r <= SC_W'(MAX_SEGMENTS)))
    else $error("store count beyond depth");

  // Matching only starts with a segment box stored
  a_start_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy && (seg_cnt_r != '0))
    else $error("matching started without segments");
`endif

endmodule
`default_nettype wire
